@@ rtl/core/class_bivariate_pixel_colorizer_core_macros.svh @@
// Assertion helpers used by the colorizer core RTL.
// Every macro samples on clk_i and is quiet while rst_ni is low.
`ifndef CLASS_BIVARIATE_PIXEL_COLORIZER_CORE_MACROS_SVH
`define CLASS_BIVARIATE_PIXEL_COLORIZER_CORE_MACROS_SVH

// Plain property that has to hold at every clock edge
`define CBPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define CBPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CBPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/cbpc_pkg.sv @@
`timescale 1ns / 1ps

package cbpc_pkg;

  // Table geometry
  localparam int unsigned CLASS_COUNT    = 256;
  localparam int unsigned CLASS_ID_W     = 8;
  localparam int unsigned CLS_W          = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned WIDX_W         = 4;
  localparam int unsigned LIMIT_COUNT    = 4;
  localparam int unsigned COEF_COUNT     = 9;
  localparam int unsigned WORD_COUNT     = LIMIT_COUNT + COEF_COUNT;
  localparam int unsigned COLOUR_COUNT   = 3;
  localparam int unsigned COEF_FRAC_BITS = 16;

  // Word index codes within one class row
  localparam logic [WIDX_W-1:0] WIDX_ELEV_MIN  = 4'd0;
  localparam logic [WIDX_W-1:0] WIDX_ELEV_MAX  = 4'd1;
  localparam logic [WIDX_W-1:0] WIDX_PREC_MIN  = 4'd2;
  localparam logic [WIDX_W-1:0] WIDX_PREC_MAX  = 4'd3;
  localparam logic [WIDX_W-1:0] WIDX_COEF_BASE = 4'd4;
  localparam logic [WIDX_W-1:0] WIDX_LAST      = 4'd12;

  // Input word kinds
  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_INVAL = 2'd2
  } kind_e;

  // Input word
  typedef struct packed {
    logic [1:0]               kind;
    logic [CLASS_ID_W-1:0]    class_id;
    logic [WIDX_W-1:0]        word_index;
    logic signed [WORD_W-1:0] word_value;
    logic signed [15:0]       elevation;
    logic [19:0]              precipitation;
    logic                     mask_in;
  } cbpc_in_t;

  // Result word
  typedef struct packed {
    logic       mask_out;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cbpc_out_t;

  // Table update command
  typedef struct packed {
    logic              wr;
    logic              inv;
    logic [CLS_W-1:0]  cls;
    logic [WIDX_W-1:0] widx;
    logic [WORD_W-1:0] data;
  } cbpc_tbl_cmd_t;

  // One class row: limits then coefficients, in word index order
  typedef logic [WORD_COUNT-1:0][WORD_W-1:0] cbpc_row_t;

endpackage

@@ rtl/core/class_bivariate_pixel_colorizer_core.sv @@
`timescale 1ns / 1ps
// Per-class bivariate pixel colorizer.
// Input channel (in_valid_i / in_stall_o / in_word_i) carries three kinds of
// word: pixels, table writes (one 32-bit word of a class row, marks the class
// valid) and class invalidates. Only pixel words produce a result word on the
// output channel (out_valid_o / out_stall_i / out_word_o); results leave in
// input order.
// Throughput: one word per cycle, sustained, for any mix of kinds, while the
// output is not stalled. The class row is held in a 13-word-wide memory that
// is read as a whole row, and each of the three colours has its own pair of
// 32x32 multipliers. A pixel passes through the table read, clamp, multiply,
// sum and colour/round stages in that order before it reaches the output.
// A table write or invalidate takes effect for the very next pixel.
// Reset clears all class valid bits and empties the pipeline; table words are
// not cleared, so every class must be fully written before use.
// When the receiver stalls, the result holds on the output and earlier stages
// keep filling until they are full; then in_stall_o rises. Nothing is dropped
// or repeated.

module class_bivariate_pixel_colorizer_core
  import cbpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  cbpc_in_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output cbpc_out_t out_word_o
);

`include "class_bivariate_pixel_colorizer_core_macros.svh"

  localparam int unsigned PROD_W = 2 * WORD_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned RND_W  = COEF_FRAC_BITS + 10;
  localparam logic signed [SUM_W-1:0] COLOUR_TOP =
    $signed({{(SUM_W - COEF_FRAC_BITS - 9){1'b0}}, 9'd256, {COEF_FRAC_BITS{1'b0}}});
  localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [7:0] COLOUR_MIN = 8'd1;
  localparam logic [7:0] COLOUR_MAX = 8'd255;

  // round half up on a positive fixed-point sum, clamp to 1..255
  function automatic logic [7:0] colour_of(input logic signed [SUM_W-1:0] s);
    logic [RND_W-1:0] r;
    logic [9:0]       q;
    r = RND_W'(s) + ROUND_HALF;
    q = r[COEF_FRAC_BITS +: 10];
    if (s <= 0) begin
      return COLOUR_MIN;
    end else if (s > COLOUR_TOP) begin
      return COLOUR_MAX;
    end else if (q > 10'(COLOUR_MAX)) begin
      return COLOUR_MAX;
    end else if (q < 10'(COLOUR_MIN)) begin
      return COLOUR_MIN;
    end else begin
      return q[7:0];
    end
  endfunction

  // stage ready chain: a stage moves when it is empty or its successor moves
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, out_rdy;
  logic in_acc, in_range;

  // stage 1: table read
  logic                     s1_vld_q, s1_msk_q;
  logic signed [15:0]       s1_elev_q;
  logic [19:0]              s1_prec_q;
  cbpc_row_t                tbl_row;
  logic                     tbl_hit;
  cbpc_tbl_cmd_t            tbl_cmd;

  // stage 2: clamped operands
  logic                     s2_vld_q, s2_msk_q;
  logic signed [WORD_W-1:0] s2_e_q, s2_p_q, s2_e_d, s2_p_d;
  logic signed [WORD_W-1:0] s2_coef_q [COEF_COUNT];

  // stage 3: products
  logic                     s3_vld_q, s3_msk_q;
  logic signed [WORD_W-1:0] s3_bias_q [COLOUR_COUNT];
  logic signed [PROD_W-1:0] s3_pe_q [COLOUR_COUNT];
  logic signed [PROD_W-1:0] s3_pp_q [COLOUR_COUNT];

  // stage 4: sums
  logic                     s4_vld_q, s4_msk_q;
  logic signed [SUM_W-1:0]  s4_sum_q [COLOUR_COUNT];

  // output register
  logic                     out_vld_q;
  cbpc_out_t                out_q, out_d;

  assign out_rdy = !out_vld_q || !out_stall_i;
  assign s4_rdy  = !s4_vld_q || out_rdy;
  assign s3_rdy  = !s3_vld_q || s4_rdy;
  assign s2_rdy  = !s2_vld_q || s3_rdy;
  assign s1_rdy  = !s1_vld_q || s2_rdy;

  assign in_stall_o = !s1_rdy;
  assign in_acc     = in_valid_i && s1_rdy;
  assign in_range   = {1'b0, in_word_i.class_id} < (CLASS_ID_W + 1)'(CLASS_COUNT);

  // table update command
  always_comb begin
    tbl_cmd      = '0;
    tbl_cmd.cls  = in_word_i.class_id[CLS_W-1:0];
    tbl_cmd.widx = in_word_i.word_index;
    tbl_cmd.data = in_word_i.word_value;
    case (in_word_i.kind)
      KIND_WRITE: tbl_cmd.wr  = in_acc && in_range && (in_word_i.word_index <= WIDX_LAST);
      KIND_INVAL: tbl_cmd.inv = in_acc && in_range;
      default:    tbl_cmd.wr  = 1'b0;
    endcase
  end

  cbpc_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (tbl_cmd),
    .rd_en_i  (s1_rdy),
    .rd_cls_i (in_word_i.class_id[CLS_W-1:0]),
    .row_o    (tbl_row),
    .hit_o    (tbl_hit)
  );

  // clamp: raise to min, then lower to max
  always_comb begin
    s2_e_d = WORD_W'(s1_elev_q);
    if (s2_e_d < $signed(tbl_row[WIDX_ELEV_MIN])) s2_e_d = $signed(tbl_row[WIDX_ELEV_MIN]);
    if (s2_e_d > $signed(tbl_row[WIDX_ELEV_MAX])) s2_e_d = $signed(tbl_row[WIDX_ELEV_MAX]);
    s2_p_d = $signed(WORD_W'(s1_prec_q));
    if (s2_p_d < $signed(tbl_row[WIDX_PREC_MIN])) s2_p_d = $signed(tbl_row[WIDX_PREC_MIN]);
    if (s2_p_d > $signed(tbl_row[WIDX_PREC_MAX])) s2_p_d = $signed(tbl_row[WIDX_PREC_MAX]);
  end

  // colour of the final sums, zero when masked off
  always_comb begin
    out_d          = '0;
    out_d.mask_out = s4_msk_q;
    if (s4_msk_q) begin
      out_d.red   = colour_of(s4_sum_q[0]);
      out_d.green = colour_of(s4_sum_q[1]);
      out_d.blue  = colour_of(s4_sum_q[2]);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_rdy)  s1_vld_q  <= in_valid_i && (in_word_i.kind == KIND_PIXEL);
      if (s2_rdy)  s2_vld_q  <= s1_vld_q;
      if (s3_rdy)  s3_vld_q  <= s2_vld_q;
      if (s4_rdy)  s4_vld_q  <= s3_vld_q;
      if (out_rdy) out_vld_q <= s4_vld_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_msk_q  <= in_word_i.mask_in && in_range;
      s1_elev_q <= in_word_i.elevation;
      s1_prec_q <= in_word_i.precipitation;
    end
    if (s2_rdy) begin
      s2_msk_q <= s1_msk_q && tbl_hit;
      s2_e_q   <= s2_e_d;
      s2_p_q   <= s2_p_d;
      for (int i = 0; i < COEF_COUNT; i++) begin
        s2_coef_q[i] <= $signed(tbl_row[LIMIT_COUNT + i]);
      end
    end
    if (s3_rdy) begin
      s3_msk_q <= s2_msk_q;
      for (int c = 0; c < COLOUR_COUNT; c++) begin
        s3_bias_q[c] <= s2_coef_q[c];
        s3_pe_q[c]   <= s2_e_q * s2_coef_q[COLOUR_COUNT + c];
        s3_pp_q[c]   <= s2_p_q * s2_coef_q[2 * COLOUR_COUNT + c];
      end
    end
    if (s4_rdy) begin
      s4_msk_q <= s3_msk_q;
      for (int c = 0; c < COLOUR_COUNT; c++) begin
        s4_sum_q[c] <= SUM_W'(s3_bias_q[c]) + SUM_W'(s3_pe_q[c]) + SUM_W'(s3_pp_q[c]);
      end
    end
    if (out_rdy) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  // a stall at the input only comes from a full first stage
  `CBPC_ASSERT_IMP(a_stall_full, in_stall_o, s1_vld_q && !s2_rdy, "input stalled with room in stage 1")
  // a masked-off pixel enters stage 1 with its mask cleared
  `CBPC_ASSERT_NXT(a_mask_entry, in_acc && (in_word_i.kind == KIND_PIXEL) && !in_word_i.mask_in, s1_vld_q && !s1_msk_q, "masked pixel kept its mask")
  // produced colours never drop to zero
  `CBPC_ASSERT_IMP(a_colour_nonzero, out_vld_q && out_q.mask_out, (out_q.red != 8'd0) && (out_q.green != 8'd0) && (out_q.blue != 8'd0), "zero colour on a produced pixel")
  // no colour without a mask
  `CBPC_ASSERT_IMP(a_colour_masked, out_vld_q && !out_q.mask_out, (out_q.red == 8'd0) && (out_q.green == 8'd0) && (out_q.blue == 8'd0), "colour on a masked-off pixel")

endmodule

@@ rtl/core/cbpc_table.sv @@
`timescale 1ns / 1ps

module cbpc_table
  import cbpc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbpc_tbl_cmd_t     cmd_i,
  input  logic              rd_en_i,
  input  logic [CLS_W-1:0]  rd_cls_i,
  output cbpc_row_t         row_o,
  output logic              hit_o
);

  logic [CLASS_COUNT-1:0] vld_q;
  logic                   hit_q;
  cbpc_row_t              mem_q [CLASS_COUNT];
  cbpc_row_t              row_q;

  // class valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        hit_q <= vld_q[rd_cls_i];
      end
      if (cmd_i.wr) begin
        vld_q[cmd_i.cls] <= 1'b1;
      end else if (cmd_i.inv) begin
        vld_q[cmd_i.cls] <= 1'b0;
      end
    end
  end

  // row memory: one word written, one full row read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[cmd_i.cls][cmd_i.widx] <= cmd_i.data;
    end
    if (rd_en_i) begin
      row_q <= mem_q[rd_cls_i];
    end
  end

  assign row_o = row_q;
  assign hit_o = hit_q;

endmodule

@@ test/colorizer_checker.sv @@
`timescale 1ns / 1ps

module colorizer_checker
  import cbpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  cbpc_in_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  cbpc_out_t out_word_i,
  output int        fail_count_o,
  output int        pending_o
);

  // Shadow copy of the class table
  logic                     class_live  [CLASS_COUNT];
  logic signed [WORD_W-1:0] class_limit [CLASS_COUNT][LIMIT_COUNT];
  logic signed [WORD_W-1:0] class_coef  [CLASS_COUNT][COEF_COUNT];

  // Colours owed by the block, oldest first
  cbpc_out_t colour_queue [$];
  cbpc_out_t want;
  cbpc_out_t got;

  // Round half away from zero and clamp into 1..255
  function automatic logic [7:0] colour_level(input logic signed [65:0] acc);
    logic signed [65:0] ceiling;
    logic signed [65:0] level;
    ceiling = 66'sd256 <<< COEF_FRAC_BITS;
    if (acc <= 0) return 8'd1;
    if (acc > ceiling) acc = ceiling;
    level = (acc + (66'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    if (level < 1) return 8'd1;
    if (level > 255) return 8'd255;
    return level[7:0];
  endfunction

  // Colours of one pixel against the current table
  function automatic cbpc_out_t shade_pixel(input cbpc_in_t w);
    cbpc_out_t          res;
    logic signed [65:0] e;
    logic signed [65:0] p;
    logic signed [65:0] acc;
    logic [2:0][7:0]    level;
    int                 c;
    res = '0;
    if (!w.mask_in || w.class_id >= CLASS_COUNT || !class_live[w.class_id]) return res;
    e = $signed(w.elevation);
    p = $signed({1'b0, w.precipitation});
    // raise to min first, then lower to max, so max wins on inverted limits
    if (e < class_limit[w.class_id][WIDX_ELEV_MIN]) e = class_limit[w.class_id][WIDX_ELEV_MIN];
    if (e > class_limit[w.class_id][WIDX_ELEV_MAX]) e = class_limit[w.class_id][WIDX_ELEV_MAX];
    if (p < class_limit[w.class_id][WIDX_PREC_MIN]) p = class_limit[w.class_id][WIDX_PREC_MIN];
    if (p > class_limit[w.class_id][WIDX_PREC_MAX]) p = class_limit[w.class_id][WIDX_PREC_MAX];
    // 66 bits hold every sum exactly; saturating at 64 bits would not move the clamp
    for (c = 0; c < COLOUR_COUNT; c++) begin
      acc = class_coef[w.class_id][c]
          + e * class_coef[w.class_id][COLOUR_COUNT + c]
          + p * class_coef[w.class_id][2 * COLOUR_COUNT + c];
      level[c] = colour_level(acc);
    end
    res.mask_out = 1'b1;
    res.red      = level[0];
    res.green    = level[1];
    res.blue     = level[2];
    return res;
  endfunction

  task automatic flag_field(input string field, input logic [7:0] exp_v,
                            input logic [7:0] act_v);
    fail_count_o++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (class_live[i]) class_live[i] = 1'b0;
      colour_queue.delete();
    end else begin
      // result side: compare with the oldest owed word
      if (out_valid_i && !out_stall_i) begin
        got = out_word_i;
        if (colour_queue.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
        end else begin
          want = colour_queue.pop_front();
          if (got.mask_out !== want.mask_out) flag_field("mask_out", want.mask_out, got.mask_out);
          if (got.red !== want.red) flag_field("red", want.red, got.red);
          if (got.green !== want.green) flag_field("green", want.green, got.green);
          if (got.blue !== want.blue) flag_field("blue", want.blue, got.blue);
        end
      end
      // input side: table updates take effect for the next pixel
      if (in_valid_i && !in_stall_i) begin
        case (in_word_i.kind)
          KIND_PIXEL: colour_queue.push_back(shade_pixel(in_word_i));
          KIND_WRITE: begin
            if (in_word_i.class_id < CLASS_COUNT && in_word_i.word_index <= WIDX_LAST) begin
              if (in_word_i.word_index < WIDX_COEF_BASE)
                class_limit[in_word_i.class_id][in_word_i.word_index] = in_word_i.word_value;
              else
                class_coef[in_word_i.class_id][in_word_i.word_index - WIDX_COEF_BASE] =
                  in_word_i.word_value;
              class_live[in_word_i.class_id] = 1'b1;
            end
          end
          KIND_INVAL: begin
            if (in_word_i.class_id < CLASS_COUNT) class_live[in_word_i.class_id] = 1'b0;
          end
          default: ;
        endcase
      end
      pending_o = colour_queue.size();
    end
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import cbpc_pkg::*;

  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         TOTAL_WORDS  = 1550;
  localparam int         HOLD_CYCLES  = 150;
  localparam int         FLOOD_WORDS  = 40;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         POOL_SIZE    = 8;
  localparam logic [1:0] KIND_SPARE   = 2'd3;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  cbpc_in_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  cbpc_out_t out_word;
  int        fail_count;
  int        pending_count;
  int        cycle_count;

  // idling controls shared with the receiver
  logic tx_eager = 1'b0;
  logic rx_eager = 1'b0;
  logic hold_req = 1'b0;
  int   words_sent = 0;

  // what the stimulus has told the table so far
  logic                  stim_live    [CLASS_COUNT];
  logic [WORD_COUNT-1:0] stim_written [CLASS_COUNT];
  logic [CLASS_ID_W-1:0] class_pool   [POOL_SIZE];

  class_bivariate_pixel_colorizer_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  colorizer_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .fail_count_o(fail_count),
    .pending_o   (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stall per word, one long hold-off on request
  initial begin : result_sink
    int wait_n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        wait_n   = HOLD_CYCLES;
      end else begin
        wait_n = rx_eager ? 0 : $urandom_range(0, 7);
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // every field random, kind and class set
  function automatic cbpc_in_t noise_word(input logic [1:0] kind,
                                          input logic [CLASS_ID_W-1:0] cls);
    cbpc_in_t w;
    w.kind          = kind;
    w.class_id      = cls;
    w.word_index    = $urandom_range(0, 15);
    w.word_value    = $urandom;
    w.elevation     = $urandom_range(0, 65535);
    w.precipitation = $urandom_range(0, 1048575);
    w.mask_in       = $urandom_range(0, 1);
    return w;
  endfunction

  // Table word for a random class row; a flat row has zero slopes and
  // offsets on an exact half, to exercise rounding
  function automatic logic signed [WORD_W-1:0] row_value(input int idx, input logic flat);
    if (flat && idx >= WIDX_COEF_BASE + COLOUR_COUNT) return '0;
    if (flat && idx >= WIDX_COEF_BASE)
      return ($urandom_range(0, 255) << COEF_FRAC_BITS) | (1 << (COEF_FRAC_BITS - 1));
    if ($urandom_range(0, 6) == 0) return $urandom;
    if (idx == WIDX_ELEV_MIN) return $urandom_range(0, 40000) - 20000;
    if (idx == WIDX_ELEV_MAX) return $urandom_range(0, 40000) - 10000;
    if (idx == WIDX_PREC_MIN) return $urandom_range(0, 300000);
    if (idx == WIDX_PREC_MAX) return $urandom_range(200000, 1048575);
    if (idx < WIDX_COEF_BASE + COLOUR_COUNT)
      return (($urandom_range(0, 300) - 20) << COEF_FRAC_BITS)
           | $urandom_range(0, (1 << COEF_FRAC_BITS) - 1);
    if (idx < WIDX_COEF_BASE + 2 * COLOUR_COUNT) return $urandom_range(0, 1024) - 512;
    return $urandom_range(0, 32) - 16;
  endfunction

  // Offer one word and hold it until accepted; returns at the next falling edge
  task automatic send_word(input cbpc_in_t w);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (w.kind == KIND_WRITE && w.word_index <= WIDX_LAST) begin
      stim_live[w.class_id]                 = 1'b1;
      stim_written[w.class_id][w.word_index] = 1'b1;
    end else if (w.kind == KIND_INVAL) begin
      stim_live[w.class_id] = 1'b0;
    end
    if (!(w.kind == KIND_SPARE || (w.kind == KIND_WRITE && w.word_index > WIDX_LAST)))
      words_sent++;
  endtask

  task automatic send_write(input logic [CLASS_ID_W-1:0] cls, input logic [WIDX_W-1:0] idx,
                            input logic [WORD_W-1:0] value);
    cbpc_in_t w;
    w            = noise_word(KIND_WRITE, cls);
    w.word_index = idx;
    w.word_value = value;
    send_word(w);
  endtask

  task automatic send_pixel(input logic [CLASS_ID_W-1:0] cls, input logic [15:0] elev,
                            input logic [19:0] prec, input logic mask);
    cbpc_in_t w;
    w               = noise_word(KIND_PIXEL, cls);
    w.elevation     = elev;
    w.precipitation = prec;
    // a live class with a word never written must not be read
    w.mask_in       = mask && !(stim_live[cls] && !(&stim_written[cls]));
    send_word(w);
  endtask

  // Write count words of a class row in shuffled order
  task automatic load_class(input logic [CLASS_ID_W-1:0] cls, input int count);
    int   order [WORD_COUNT];
    int   j;
    int   tmp;
    logic flat;
    flat = ($urandom_range(0, 7) == 0);
    foreach (order[k]) order[k] = k;
    for (int k = WORD_COUNT - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < count; k++) send_write(cls, order[k], row_value(order[k], flat));
  endtask

  initial begin : stimulus
    int              pick;
    int              burst;
    logic            hold_done;
    logic            pause_done;
    logic [CLASS_ID_W-1:0] cls;
    cbpc_in_t        w;

    hold_done  = 1'b0;
    pause_done = 1'b0;
    foreach (stim_live[i]) begin
      stim_live[i]    = 1'b0;
      stim_written[i] = '0;
    end
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // unknown class, then masked-off pixel
    send_pixel(8'd5, 16'sd100, 20'd10, 1'b1);
    send_pixel(8'd5, 16'h8000, 20'd0, 1'b0);

    // class 255: inverted elevation limits, extreme words, sums past 64 bits
    send_write(8'd255, WIDX_ELEV_MIN, 32'h7FFF_FFFF);
    send_write(8'd255, WIDX_ELEV_MAX, 32'h8000_0000);
    send_write(8'd255, WIDX_PREC_MIN, 32'h8000_0000);
    send_write(8'd255, WIDX_PREC_MAX, 32'h8000_0000);
    send_write(8'd255, WIDX_COEF_BASE + 0, 32'h7FFF_FFFF);
    send_write(8'd255, WIDX_COEF_BASE + 1, 32'h8000_0000);
    send_write(8'd255, WIDX_COEF_BASE + 2, (200 << COEF_FRAC_BITS) | (1 << (COEF_FRAC_BITS - 1)));
    send_write(8'd255, WIDX_COEF_BASE + 3, 32'h8000_0000);
    send_write(8'd255, WIDX_COEF_BASE + 4, 32'h8000_0000);
    send_write(8'd255, WIDX_COEF_BASE + 5, 32'h0000_0000);
    send_write(8'd255, WIDX_COEF_BASE + 6, 32'h8000_0000);
    send_write(8'd255, WIDX_COEF_BASE + 7, 32'h7FFF_FFFF);
    send_write(8'd255, WIDX_LAST, 32'h0000_0000);
    send_pixel(8'd255, 16'h8000, 20'd0, 1'b1);
    send_pixel(8'd255, 16'h7FFF, 20'hFFFFF, 1'b1);

    // write with an index past the row: ignored, class stays unknown
    w            = noise_word(KIND_WRITE, 8'd9);
    w.word_index = WIDX_LAST + 1 + $urandom_range(0, 2);
    send_word(w);
    send_pixel(8'd9, 16'sd0, 20'd0, 1'b1);
    send_word(noise_word(KIND_SPARE, 8'd255));

    // invalidate keeps the words; one write revives the class
    send_word(noise_word(KIND_INVAL, 8'd255));
    send_pixel(8'd255, 16'sd0, 20'd0, 1'b1);
    send_write(8'd255, WIDX_COEF_BASE + 2, (3 << COEF_FRAC_BITS) | 32'h7FFF);
    send_pixel(8'd255, 16'sd0, 20'd0, 1'b1);

    // random part: a pool of classes that pixels mostly hit
    class_pool[0] = 8'd0;
    class_pool[1] = 8'd255;
    for (int k = 2; k < POOL_SIZE; k++) class_pool[k] = $urandom_range(0, 255);
    foreach (class_pool[k]) load_class(class_pool[k], WORD_COUNT);

    while (words_sent < TOTAL_WORDS) begin
      if ($urandom_range(0, 31) == 0) begin
        tx_eager = ($urandom_range(0, 2) == 0);
        rx_eager = ($urandom_range(0, 2) == 0);
      end
      cls  = ($urandom_range(0, 9) < 8) ? class_pool[$urandom_range(0, POOL_SIZE - 1)]
                                        : $urandom_range(0, 255);
      pick = $urandom_range(0, 99);
      if (!hold_done && words_sent > 600) begin
        // receiver holds off while pixels keep coming, so the block backs up
        hold_done = 1'b1;
        hold_req  = 1'b1;
        tx_eager  = 1'b1;
        repeat (FLOOD_WORDS)
          send_pixel(class_pool[$urandom_range(0, POOL_SIZE - 1)], $urandom_range(0, 65535),
                     $urandom_range(0, 1048575), 1'b1);
        tx_eager = 1'b0;
      end else if (!pause_done && words_sent > 1100) begin
        // sender goes quiet until every colour is back
        pause_done = 1'b1;
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        @(negedge clk);
      end else if (pick < 8) begin
        load_class(cls, WORD_COUNT);
      end else if (pick < 11) begin
        send_word(noise_word(KIND_INVAL, cls));
      end else if (pick < 14) begin
        load_class($urandom_range(0, 255), $urandom_range(1, WORD_COUNT - 1));
      end else if (pick < 16) begin
        w = noise_word(($urandom_range(0, 1) == 0) ? KIND_SPARE : KIND_WRITE, cls);
        if (w.kind == KIND_WRITE) w.word_index = WIDX_LAST + 1 + $urandom_range(0, 2);
        send_word(w);
      end else begin
        burst = $urandom_range(1, 8);
        repeat (burst)
          send_pixel(cls, $urandom_range(0, 65535), $urandom_range(0, 1048575),
                     $urandom_range(0, 9) != 0);
      end
    end

    // drain
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
